@@ rtl/wrt_pkg.sv @@
// shared types and constants for the windowed rate write throttle
`default_nettype none

package wrt_pkg;

    localparam int unsigned WINDOW_DEPTH_DEF = 256;
    localparam int unsigned ENTRY_W          = 96;
    localparam int unsigned CFG_ADDR_W       = 3;
    localparam int unsigned CFG_DATA_W       = 32;

    localparam logic [63:0] ALL_ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic OP_COMPACT = 1'b0;
    localparam logic OP_POLL    = 1'b1;

    localparam logic        RST_ENABLE     = 1'b1;
    localparam logic [15:0] RST_START_TH   = 16'hFFFF;
    localparam logic [15:0] RST_STOP_TH    = 16'h0000;
    localparam logic [8:0]  RST_WINDOW_LEN = 9'd100;
    localparam logic [31:0] RST_INTERVAL   = 32'd0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ENABLE     = 3'd0,
        REG_START_TH   = 3'd1,
        REG_STOP_TH    = 3'd2,
        REG_WINDOW_LEN = 3'd3,
        REG_INTERVAL   = 3'd4
    } wrt_reg_idx_t;

    typedef struct packed {
        logic        op;
        logic [63:0] stamp;
        logic [31:0] chunk_block_count;
        logic        compaction_stopped;
        logic [15:0] full_chunks;
        logic [47:0] free_cnt;
        logic [47:0] free_goal;
    } wrt_item_t;

    typedef struct packed {
        logic [63:0] submit_limit;
        logic        limit_unbounded;
        logic        throttle_active;
        logic [63:0] rate_q32;
    } wrt_result_t;

    typedef struct packed {
        logic        throttle_enable;
        logic [15:0] start_threshold;
        logic [15:0] stop_threshold;
        logic [8:0]  window_len;
        logic [31:0] interval_ticks;
    } wrt_cfg_t;

    typedef struct packed {
        logic        is_poll;
        logic [63:0] stamp;
        logic [31:0] blocks;
        logic        stopped;
        logic [15:0] full_chunks;
        logic [47:0] free_cnt;
        logic [47:0] free_goal;
        logic        target_zero;
    } wrt_cmd_t;

endpackage

`default_nettype wire

@@ rtl/windowed_rate_write_throttle.sv @@
// top level of the windowed rate write throttle
//
//   channel   direction  handshake           word
//   item      in         push / full         wrt_item_t
//   result    out        pop / empty         wrt_result_t
//   config    in         cfg_wr_en           cfg_addr, cfg_wdata
//
// after reset the ring is cleared one entry a cycle, with full held high
// compaction word: a sum sweep over the window, then the rate divide if the summed period is nonzero
// poll word: a direct result, or a divide for the free ratio followed by two multiplies
// one word is worked at a time; a waiting result holds the next word in the two-entry input queue
`default_nettype none

module windowed_rate_write_throttle
    import wrt_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire wrt_item_t             item,
    output logic                       empty,
    input  wire logic                  pop,
    output wrt_result_t                result,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    wrt_cfg_t cfg_reg;
    wrt_cmd_t cmd;
    logic     cmd_empty;
    logic     cmd_pop;
    logic     clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.throttle_enable <= RST_ENABLE;
            cfg_reg.start_threshold <= RST_START_TH;
            cfg_reg.stop_threshold  <= RST_STOP_TH;
            cfg_reg.window_len      <= RST_WINDOW_LEN;
            cfg_reg.interval_ticks  <= RST_INTERVAL;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_ENABLE:     cfg_reg.throttle_enable <= cfg_wdata[0];
                REG_START_TH:   cfg_reg.start_threshold <= cfg_wdata[15:0];
                REG_STOP_TH:    cfg_reg.stop_threshold  <= cfg_wdata[15:0];
                REG_WINDOW_LEN: cfg_reg.window_len      <= cfg_wdata[8:0];
                REG_INTERVAL:   cfg_reg.interval_ticks  <= cfg_wdata[31:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    wrt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .hold      (clearing),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    wrt_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .clearing  (clearing),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

@@ rtl/wrt_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module wrt_ram
    import wrt_pkg::*;
#(
    parameter int unsigned WIDTH = ENTRY_W,
    parameter int unsigned DEPTH = WINDOW_DEPTH_DEF,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/wrt_front.sv @@
// input side: classifies each word and queues it for the engine
`default_nettype none

module wrt_front
    import wrt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire wrt_item_t item,
    input  wire logic      hold,
    output logic           full,
    input  wire logic      cmd_pop,
    output wrt_cmd_t       cmd,
    output logic           cmd_empty
);

    wrt_cmd_t   q_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    wrt_cmd_t   cmd_in;
    logic       accept;
    logic       take;

    always_comb
    begin
        cmd_in.is_poll     = (item.op == OP_POLL);
        cmd_in.stamp       = item.stamp;
        cmd_in.blocks      = item.chunk_block_count;
        cmd_in.stopped     = item.compaction_stopped;
        cmd_in.full_chunks = item.full_chunks;
        cmd_in.free_cnt    = item.free_cnt;
        cmd_in.free_goal   = item.free_goal;
        cmd_in.target_zero = (item.free_goal == 48'd0);
    end

    assign full      = (cnt_reg == 2'd2) || hold;
    assign accept    = push && !full;
    assign cmd_empty = (cnt_reg == 2'd0);
    assign take      = cmd_pop && !cmd_empty;
    assign cmd       = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wp_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg <= !wp_reg;
            end
            if (take)
            begin
                rp_reg <= !rp_reg;
            end
            case ({accept, take})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/wrt_div.sv @@
// radix-2 restoring divider, 128 by 64 bits, saturating quotient
`default_nettype none

module wrt_div
    import wrt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] hi,
    input  wire logic [63:0] lo,
    input  wire logic [63:0] d,
    output logic             done,
    output logic [63:0]      q
);

    logic [63:0] d_reg;
    logic [63:0] rem_reg;
    logic [63:0] lo_reg;
    logic [63:0] q_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [63:0] rem_sh;
    logic        sub;

    assign rem_sh = {rem_reg[62:0], lo_reg[63]};
    assign sub    = rem_reg[63] || (rem_sh >= d_reg);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg   <= d;
            rem_reg <= hi;
            lo_reg  <= lo;
            q_reg   <= (d == 64'd0 || hi >= d) ? ALL_ONES64 : 64'd0;
        end
        else if (run_reg)
        begin
            rem_reg <= sub ? (rem_sh - d_reg) : rem_sh;
            lo_reg  <= {lo_reg[62:0], 1'b0};
            q_reg   <= {q_reg[62:0], sub};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 6'd63;
                // overflow or zero divisor finishes at once
                if (d == 64'd0 || hi >= d)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                end
            end
            else if (run_reg)
            begin
                if (cnt_reg == 6'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

    assert property (@(posedge clk) disable iff (!rst_n) run_reg |-> !done_reg)
        else $error("divider done while still iterating");

endmodule

`default_nettype wire

@@ rtl/wrt_mul.sv @@
// 64 by 64 multiplier built from four 32 by 32 partial products
`default_nettype none

module wrt_mul
    import wrt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [63:0]  a,
    input  wire logic [63:0]  b,
    output logic              done,
    output logic [127:0]      p
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  prod_reg;
    logic [1:0]   sh_reg;
    logic [127:0] acc_reg;
    logic [2:0]   cnt_reg;
    logic         run_reg;
    logic         done_reg;
    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [127:0] prod_sh;

    assign a_part = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_part = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb
    begin
        case (sh_reg)
            2'd0:    prod_sh = {64'd0, prod_reg};
            2'd1:    prod_sh = {32'd0, prod_reg, 32'd0};
            2'd2:    prod_sh = {prod_reg, 64'd0};
            default: prod_sh = 128'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= 128'd0;
        end
        else if (run_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                prod_reg <= {32'd0, a_part} * {32'd0, b_part};
                sh_reg   <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg != 3'd0)
            begin
                acc_reg <= acc_reg + prod_sh;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 3'd0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (cnt_reg == 3'd4)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

@@ rtl/wrt_back.sv @@
// engine: ring window, sums, rate and limit calculation, result register
`default_nettype none

module wrt_back
    import wrt_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire wrt_cfg_t cfg,
    input  wire wrt_cmd_t cmd,
    input  wire logic     cmd_empty,
    output logic          cmd_pop,
    output logic          clearing,
    output wrt_result_t   result,
    output logic          empty,
    input  wire logic     pop
);

    localparam int unsigned AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned CMPW = (CW > 9) ? CW : 9;
    localparam int unsigned SBW  = 32 + AW;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SWEEP = 7'b0000100,
        S_RDIV  = 7'b0001000,
        S_PDIV  = 7'b0010000,
        S_MUL1  = 7'b0100000,
        S_MUL2  = 7'b1000000
    } wrt_state_t;

    wrt_state_t       state_reg;
    wrt_state_t       state_next;
    logic [AW-1:0]    clr_cnt_reg;
    logic [AW-1:0]    ring_pos_reg;
    logic [63:0]      last_stamp_reg;
    logic [SBW-1:0]   sum_blocks_reg;
    logic [63:0]      sum_period_reg;
    logic             active_reg;
    logic [63:0]      rate_reg;
    logic [63:0]      ratio_reg;
    logic             stopped_reg;
    logic [CW-1:0]    iss_cnt_reg;
    logic             rd_pend_reg;
    wrt_result_t      out_reg;
    wrt_result_t      out_next;
    logic             out_valid_reg;

    logic [CMPW-1:0]  win_cmp;
    logic [CW-1:0]    n_eff;
    logic [CW-1:0]    pos_inc;
    logic [AW-1:0]    pos_new;
    logic             go;
    logic             poll_calc;
    logic             new_active;
    logic             sweep_end;
    logic             emit;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic             div_start;
    logic [63:0]      div_hi;
    logic [63:0]      div_lo;
    logic [63:0]      div_d;
    logic             div_done;
    logic [63:0]      div_q;
    logic             mul_start;
    logic [63:0]      mul_a;
    logic [63:0]      mul_b;
    logic             mul_done;
    logic [127:0]     mul_p;

    // window length clipped to 1..depth
    assign win_cmp = CMPW'(cfg.window_len);
    always_comb
    begin
        if (win_cmp == '0)
        begin
            n_eff = CW'(1);
        end
        else if (win_cmp > CMPW'(WINDOW_DEPTH))
        begin
            n_eff = CW'(WINDOW_DEPTH);
        end
        else
        begin
            n_eff = CW'(win_cmp);
        end
    end

    assign pos_inc = CW'(ring_pos_reg) + CW'(1);
    assign pos_new = (pos_inc >= n_eff) ? '0 : pos_inc[AW-1:0];

    assign go      = (state_reg == S_IDLE) && !cmd_empty && !out_valid_reg;
    assign cmd_pop = go;

    always_comb
    begin
        if (rate_reg == 64'd0 || !cfg.throttle_enable)
        begin
            new_active = 1'b0;
        end
        else if (!active_reg)
        begin
            new_active = (cmd.full_chunks >= cfg.start_threshold);
        end
        else if (cmd.full_chunks < cfg.stop_threshold)
        begin
            new_active = 1'b0;
        end
        else
        begin
            new_active = 1'b1;
        end
    end

    assign poll_calc = (rate_reg != 64'd0) && cfg.throttle_enable && active_reg
                       && (cmd.full_chunks >= cfg.stop_threshold) && !cmd.target_zero;

    assign sweep_end = (state_reg == S_SWEEP) && (iss_cnt_reg == n_eff) && !rd_pend_reg;

    // ring writes: clearing pass, or the new entry of a compaction word once an earlier stamp is held
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos_new;
        ram_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else if (go && !cmd.is_poll && last_stamp_reg != 64'd0)
        begin
            ram_we = 1'b1;
            // an entry with a zero stop stamp never counts
            if (cmd.stamp != 64'd0)
            begin
                ram_wdata = {cmd.blocks, cmd.stamp - last_stamp_reg};
            end
        end
    end

    wrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (iss_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign div_start = (sweep_end && sum_period_reg != 64'd0) || (go && cmd.is_poll && poll_calc);
    always_comb
    begin
        if (state_reg == S_SWEEP)
        begin
            div_hi = 64'(sum_blocks_reg[SBW-1:32]);
            div_lo = {sum_blocks_reg[31:0], 32'd0};
            div_d  = sum_period_reg;
        end
        else
        begin
            div_hi = 64'd0;
            div_lo = {cmd.free_cnt, 16'd0};
            div_d  = {16'd0, cmd.free_goal};
        end
    end

    wrt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .hi    (div_hi),
        .lo    (div_lo),
        .d     (div_d),
        .done  (div_done),
        .q     (div_q)
    );

    assign mul_start = ((state_reg == S_PDIV) && div_done) || ((state_reg == S_MUL1) && mul_done);
    assign mul_a     = (state_reg == S_PDIV) ? rate_reg : mul_p[95:32];
    assign mul_b     = (state_reg == S_PDIV) ? {32'd0, cfg.interval_ticks} : ratio_reg;

    wrt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    assign emit = (go && cmd.is_poll && !poll_calc)
                  || (sweep_end && sum_period_reg == 64'd0)
                  || ((state_reg == S_RDIV) && div_done)
                  || ((state_reg == S_MUL2) && mul_done);

    always_comb
    begin
        out_next.submit_limit    = ALL_ONES64;
        out_next.limit_unbounded = 1'b1;
        out_next.throttle_active = active_reg;
        out_next.rate_q32        = rate_reg;
        if (state_reg == S_IDLE)
        begin
            out_next.throttle_active = new_active;
        end
        else if (state_reg == S_SWEEP)
        begin
            out_next.rate_q32 = 64'd0;
        end
        else if (state_reg == S_RDIV)
        begin
            out_next.rate_q32 = div_q;
        end
        else if (state_reg == S_MUL2)
        begin
            out_next.submit_limit    = (mul_p[127:80] != '0) ? ALL_ONES64 : mul_p[79:16];
            out_next.limit_unbounded = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == AW'(WINDOW_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (go)
                begin
                    if (!cmd.is_poll)
                    begin
                        state_next = S_SWEEP;
                    end
                    else if (poll_calc)
                    begin
                        state_next = S_PDIV;
                    end
                end
            end
            S_SWEEP:
            begin
                if (sweep_end)
                begin
                    state_next = (sum_period_reg != 64'd0) ? S_RDIV : S_IDLE;
                end
            end
            S_RDIV:
            begin
                if (div_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PDIV:
            begin
                if (div_done)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                if (mul_done)
                begin
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (mul_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= out_next;
        end
        if ((state_reg == S_PDIV) && div_done)
        begin
            ratio_reg <= div_q;
        end
        if (go)
        begin
            stopped_reg <= cmd.stopped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            ring_pos_reg   <= '0;
            last_stamp_reg <= 64'd0;
            sum_blocks_reg <= '0;
            sum_period_reg <= 64'd0;
            active_reg     <= 1'b0;
            rate_reg       <= 64'd0;
            iss_cnt_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end

            if (go)
            begin
                if (cmd.is_poll)
                begin
                    active_reg <= new_active;
                end
                else
                begin
                    last_stamp_reg <= cmd.stamp;
                    if (last_stamp_reg != 64'd0)
                    begin
                        ring_pos_reg <= pos_new;
                    end
                    sum_blocks_reg <= '0;
                    sum_period_reg <= 64'd0;
                    iss_cnt_reg    <= '0;
                    rd_pend_reg    <= 1'b0;
                end
            end

            if (state_reg == S_SWEEP)
            begin
                // one read issued per cycle, its data back in the next cycle
                if (iss_cnt_reg != n_eff)
                begin
                    iss_cnt_reg <= iss_cnt_reg + CW'(1);
                end
                rd_pend_reg <= (iss_cnt_reg != n_eff);
                if (rd_pend_reg)
                begin
                    sum_blocks_reg <= sum_blocks_reg + SBW'(ram_rdata[95:64]);
                    sum_period_reg <= sum_period_reg + ram_rdata[63:0];
                end
                if (sweep_end)
                begin
                    if (stopped_reg)
                    begin
                        last_stamp_reg <= 64'd0;
                    end
                    if (sum_period_reg == 64'd0)
                    begin
                        rate_reg <= 64'd0;
                    end
                end
            end

            if ((state_reg == S_RDIV) && div_done)
            begin
                rate_reg <= div_q;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign clearing = (state_reg == S_CLEAR);
    assign result   = out_reg;
    assign empty    = !out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n) emit |-> !out_valid_reg)
        else $error("result word overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == S_RDIV || state_reg == S_PDIV))
        else $error("divider started outside a divide step");

    assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |=> (state_reg == S_MUL1 || state_reg == S_MUL2))
        else $error("multiplier started outside a multiply step");

    assert property (@(posedge clk) disable iff (!rst_n) rd_pend_reg |-> state_reg == S_SWEEP)
        else $error("window read pending outside the sum sweep");

endmodule

`default_nettype wire
